[src/can_acceptance_filter_table_assert.svh]
// Assertion macros shared by the acceptance filter table modules.
`ifndef CAN_ACCEPTANCE_FILTER_TABLE_ASSERT_SVH
`define CAN_ACCEPTANCE_FILTER_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CAFT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CAFT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/caft_pkg.sv]
// Shared types and constants of the CAN acceptance filter table.
`default_nettype none

package caft_pkg;

	// Field widths
	localparam int ID_W   = 32;
	localparam int LEN_W  = 4;
	localparam int DATA_W = 64;
	localparam int LVL_W  = 13;
	localparam int ST_W   = 3;
	localparam int MIDX_W = 4;
	localparam int TOT_W  = 5;
	localparam int SUM_W  = 11;   // eight bytes of 255
	localparam int K_W    = 11;   // 255 * 8
	localparam int PROD_W = 24;   // both sides of the level compare

	localparam int                ERR_BIT       = 29;
	localparam logic [LVL_W-1:0]  FULL_SCALE_MV = 13'd5000;
	localparam logic [LEN_W-1:0]  MAX_LEN       = 4'd8;

	// Command codes
	localparam logic CMD_CHECK = 1'b0;
	localparam logic CMD_ADD   = 1'b1;

	// Result status codes
	localparam logic [ST_W-1:0] ST_EMPTY   = 3'd0;
	localparam logic [ST_W-1:0] ST_MATCH   = 3'd1;
	localparam logic [ST_W-1:0] ST_ERROR   = 3'd2;
	localparam logic [ST_W-1:0] ST_NOMATCH = 3'd3;
	localparam logic [ST_W-1:0] ST_ADDED   = 3'd4;
	localparam logic [ST_W-1:0] ST_FULL    = 3'd5;

	// Result register select codes
	localparam logic [2:0] RES_NONE  = 3'd0;
	localparam logic [2:0] RES_ADD   = 3'd1;
	localparam logic [2:0] RES_EMPTY = 3'd2;
	localparam logic [2:0] RES_HIT   = 3'd3;
	localparam logic [2:0] RES_MISS  = 3'd4;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [ID_W-1:0]  mask;
		logic [LVL_W-1:0] min_level;
	} entry_t;

	// Controller to datapath
	typedef struct packed {
		logic       capture;
		logic       prep;
		logic       lhs;
		logic       scan;
		logic       flush;
		logic [2:0] res_sel;
		logic       load_out;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic is_add;
		logic empty;
		logic hit;
		logic drained;
	} dp_sts_t;

endpackage

`default_nettype wire

[src/caft_req_if.sv]
// Request channel: frame checks and filter adds.
`default_nettype none

interface caft_req_if;
	logic                                valid;
	logic                                ready;
	logic                                command;
	logic [caft_pkg::ID_W-1:0]           frame_id;
	logic [caft_pkg::LEN_W-1:0]          frame_length;
	logic [caft_pkg::DATA_W-1:0]         frame_data;
	logic [caft_pkg::ID_W-1:0]           filter_id;
	logic [caft_pkg::ID_W-1:0]           filter_mask;
	logic [caft_pkg::LVL_W-1:0]          filter_min_level;

	modport source (
		output valid, command, frame_id, frame_length, frame_data,
		       filter_id, filter_mask, filter_min_level,
		input  ready
	);

	modport sink (
		input  valid, command, frame_id, frame_length, frame_data,
		       filter_id, filter_mask, filter_min_level,
		output ready
	);
endinterface

`default_nettype wire

[src/caft_rsp_if.sv]
// Response channel: one result per request.
`default_nettype none

interface caft_rsp_if;
	logic                         valid;
	logic                         ready;
	logic                         accepted;
	logic [caft_pkg::ST_W-1:0]    status;
	logic [caft_pkg::MIDX_W-1:0]  matched_index;
	logic [caft_pkg::TOT_W-1:0]   filter_total;

	modport source (
		output valid, accepted, status, matched_index, filter_total,
		input  ready
	);

	modport sink (
		input  valid, accepted, status, matched_index, filter_total,
		output ready
	);
endinterface

`default_nettype wire

[src/caft_ctrl.sv]
// Controller state machine of the acceptance filter table.
`default_nettype none
`include "can_acceptance_filter_table_assert.svh"

module caft_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	input  caft_pkg::dp_sts_t sts,
	output caft_pkg::dp_cmd_t cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_LHS    = 3'd2;
	localparam logic [2:0] S_SCAN   = 3'd3;
	localparam logic [2:0] S_FINISH = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       rsp_valid_q;
	logic       slot_free;

	assign slot_free = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;

	// Sequence one request through decode, scan and result hand-off
	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		cmd       = '0;
		cmd.res_sel = caft_pkg::RES_NONE;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.prep = 1'b1;
				if (sts.is_add) begin
					cmd.res_sel = caft_pkg::RES_ADD;
					state_d     = S_FINISH;
				end else if (sts.empty) begin
					cmd.res_sel = caft_pkg::RES_EMPTY;
					state_d     = S_FINISH;
				end else begin
					state_d = S_LHS;
				end
			end
			S_LHS: begin
				cmd.lhs = 1'b1;
				state_d = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.hit) begin
					cmd.flush   = 1'b1;
					cmd.res_sel = caft_pkg::RES_HIT;
					state_d     = S_FINISH;
				end else if (sts.drained) begin
					cmd.res_sel = caft_pkg::RES_MISS;
					state_d     = S_FINISH;
				end
			end
			S_FINISH: begin
				if (slot_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Advance state, hold the response until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	`CAFT_ASSERT_NXT(a_accept_decode, clk, arst_n, req_valid && req_ready, state_q == S_DECODE, "accepted request did not enter decode")
	`CAFT_ASSERT_NXT(a_load_valid, clk, arst_n, cmd.load_out, rsp_valid_q && state_q == S_IDLE, "loaded result not presented")
	`CAFT_ASSERT_NXT(a_hit_finish, clk, arst_n, state_q == S_SCAN && sts.hit, state_q == S_FINISH, "scan hit did not finish")

endmodule

`default_nettype wire

[src/caft_dp.sv]
// Datapath: filter memory, level arithmetic, scan pipeline and result registers.
`default_nettype none
`include "can_acceptance_filter_table_assert.svh"

module caft_dp #(
	parameter int FILTER_SLOTS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          command,
	input  logic [caft_pkg::ID_W-1:0]     frame_id,
	input  logic [caft_pkg::LEN_W-1:0]    frame_length,
	input  logic [caft_pkg::DATA_W-1:0]   frame_data,
	input  logic [caft_pkg::ID_W-1:0]     filter_id,
	input  logic [caft_pkg::ID_W-1:0]     filter_mask,
	input  logic [caft_pkg::LVL_W-1:0]    filter_min_level,
	input  caft_pkg::dp_cmd_t             cmd,
	output caft_pkg::dp_sts_t             sts,
	output logic                          accepted,
	output logic [caft_pkg::ST_W-1:0]     status,
	output logic [caft_pkg::MIDX_W-1:0]   matched_index,
	output logic [caft_pkg::TOT_W-1:0]    filter_total
);

	localparam int CNT_W = $clog2(FILTER_SLOTS + 1);
	localparam int IDX_W = (FILTER_SLOTS > 1) ? $clog2(FILTER_SLOTS) : 1;

	// Captured request
	logic                          command_q;
	logic [caft_pkg::ID_W-1:0]     fid_q;
	logic [caft_pkg::LEN_W-1:0]    len_q;
	logic [caft_pkg::DATA_W-1:0]   data_q;
	caft_pkg::entry_t              new_q;

	// Table
	caft_pkg::entry_t              mem_q [FILTER_SLOTS];
	logic [CNT_W-1:0]              count_q;
	logic                          full;
	logic                          wr_en;

	// Level arithmetic
	logic [caft_pkg::LEN_W-1:0]    len_sat;
	logic [caft_pkg::SUM_W-1:0]    sum;
	logic [caft_pkg::K_W-1:0]      len_ext;
	logic [caft_pkg::SUM_W-1:0]    sum_q;
	logic [caft_pkg::K_W-1:0]      k_q;
	logic [caft_pkg::PROD_W-1:0]   lhs_q;

	// Scan pipeline
	logic [CNT_W-1:0]              ptr_q;
	logic                          more;
	logic                          issue;
	logic                          valid_s1;
	logic [IDX_W-1:0]              idx_s1;
	caft_pkg::entry_t              ent_s1;
	logic                          valid_s2;
	logic [IDX_W-1:0]              idx_s2;
	logic                          match_s2;
	logic [caft_pkg::PROD_W-1:0]   rhs_s2;
	logic                          hit;
	logic                          drained;

	// Result
	logic                          res_acc_q;
	logic [caft_pkg::ST_W-1:0]     res_st_q;
	logic [IDX_W-1:0]              res_idx_q;
	logic [IDX_W+caft_pkg::MIDX_W-1:0] idx_ext;
	logic [CNT_W+caft_pkg::TOT_W-1:0]  tot_ext;
	logic                          accepted_q;
	logic [caft_pkg::ST_W-1:0]     status_q;
	logic [caft_pkg::MIDX_W-1:0]   matched_index_q;
	logic [caft_pkg::TOT_W-1:0]    filter_total_q;

	assign full  = (count_q == CNT_W'(FILTER_SLOTS));
	assign wr_en = (cmd.res_sel == caft_pkg::RES_ADD) && !full;
	assign more  = (ptr_q < count_q);
	assign issue = cmd.scan && !cmd.flush && more;
	assign hit   = valid_s2 && match_s2 && (lhs_q >= rhs_s2);
	assign drained = !more && !valid_s1 && !valid_s2;

	assign sts.is_add  = (command_q == caft_pkg::CMD_ADD);
	assign sts.empty   = (count_q == '0);
	assign sts.hit     = hit;
	assign sts.drained = drained;

	// Capture the request payload
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			command_q         <= command;
			fid_q             <= frame_id;
			len_q             <= frame_length;
			data_q            <= frame_data;
			new_q.id          <= filter_id;
			new_q.mask        <= filter_mask;
			new_q.min_level   <= filter_min_level;
		end
	end

	// Saturate the length and add the bytes inside it
	always_comb begin
		len_sat = (len_q > caft_pkg::MAX_LEN) ? caft_pkg::MAX_LEN : len_q;
		sum     = '0;
		for (int i = 0; i < 8; i++) begin
			if (caft_pkg::LEN_W'(i) < len_sat) begin
				sum = sum + caft_pkg::SUM_W'(data_q[8*i +: 8]);
			end
		end
		len_ext = {{(caft_pkg::K_W-caft_pkg::LEN_W){1'b0}}, len_sat};
	end

	// Register sum and 255 * length, then 5000 * sum
	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			sum_q <= sum;
			k_q   <= (len_ext << 8) - len_ext;
		end
		if (cmd.lhs) begin
			lhs_q <= {{(caft_pkg::PROD_W-caft_pkg::SUM_W){1'b0}}, sum_q}
			       * {{(caft_pkg::PROD_W-caft_pkg::LVL_W){1'b0}}, caft_pkg::FULL_SCALE_MV};
		end
	end

	// Append a filter at the end of the table
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[count_q[IDX_W-1:0]] <= new_q;
		end
	end

	// Read one entry per cycle during the scan
	always_ff @(posedge clk) begin
		if (issue) begin
			ent_s1 <= mem_q[ptr_q[IDX_W-1:0]];
			idx_s1 <= ptr_q[IDX_W-1:0];
		end
		if (valid_s1) begin
			idx_s2   <= idx_s1;
			match_s2 <= ((fid_q & ent_s1.mask) == (ent_s1.id & ent_s1.mask));
			rhs_s2   <= {{(caft_pkg::PROD_W-caft_pkg::LVL_W){1'b0}}, ent_s1.min_level}
			          * {{(caft_pkg::PROD_W-caft_pkg::K_W){1'b0}}, k_q};
		end
	end

	// Count, scan pointer and stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			ptr_q    <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (wr_en) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.prep) begin
				ptr_q <= '0;
			end else if (issue) begin
				ptr_q <= ptr_q + 1'b1;
			end
			if (cmd.flush) begin
				valid_s1 <= 1'b0;
				valid_s2 <= 1'b0;
			end else begin
				valid_s1 <= issue;
				valid_s2 <= valid_s1;
			end
		end
	end

	// Record the outcome of the request
	always_ff @(posedge clk) begin
		unique case (cmd.res_sel)
			caft_pkg::RES_ADD: begin
				res_acc_q <= !full;
				res_st_q  <= full ? caft_pkg::ST_FULL : caft_pkg::ST_ADDED;
				res_idx_q <= '0;
			end
			caft_pkg::RES_EMPTY: begin
				res_acc_q <= 1'b1;
				res_st_q  <= caft_pkg::ST_EMPTY;
				res_idx_q <= '0;
			end
			caft_pkg::RES_HIT: begin
				res_acc_q <= !fid_q[caft_pkg::ERR_BIT];
				res_st_q  <= fid_q[caft_pkg::ERR_BIT] ? caft_pkg::ST_ERROR : caft_pkg::ST_MATCH;
				res_idx_q <= idx_s2;
			end
			caft_pkg::RES_MISS: begin
				res_acc_q <= 1'b0;
				res_st_q  <= caft_pkg::ST_NOMATCH;
				res_idx_q <= '0;
			end
			default: begin
				res_acc_q <= res_acc_q;
			end
		endcase
	end

	assign idx_ext = {{caft_pkg::MIDX_W{1'b0}}, res_idx_q};
	assign tot_ext = {{caft_pkg::TOT_W{1'b0}}, count_q};

	// Load the response register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			accepted_q      <= res_acc_q;
			status_q        <= res_st_q;
			matched_index_q <= idx_ext[caft_pkg::MIDX_W-1:0];
			filter_total_q  <= tot_ext[caft_pkg::TOT_W-1:0];
		end
	end

	assign accepted      = accepted_q;
	assign status        = status_q;
	assign matched_index = matched_index_q;
	assign filter_total  = filter_total_q;

	`CAFT_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(FILTER_SLOTS), "filter count beyond table size")
	`CAFT_ASSERT_IMP(a_hit_not_drained, clk, arst_n, hit, !drained, "hit reported with empty pipeline")
	`CAFT_ASSERT_NXT(a_issue_stage, clk, arst_n, issue, valid_s1 && idx_s1 == $past(ptr_q[IDX_W-1:0]), "issued read lost")

endmodule

`default_nettype wire

[src/can_acceptance_filter_table.sv]
// Top level of the CAN acceptance filter table.
//
//   channel  role    handshake     contents
//   cmd      sink    valid/ready   command, frame fields, new filter fields
//   rsp      source  valid/ready   accepted, status, matched_index, filter_total
//
// One request is in work at a time; cmd.ready is high only while idle.
// Add, or check against an empty table: decode, then the finish state loads the response.
// Check: decode, level product, then a scan that stops at the first hit or after the last entry;
// the scan reads one filter memory entry per cycle through a two-stage pipeline.
// A response not yet taken stalls the next result in the finish state only.
// Reset empties the table; filter entries need no clearing.
`default_nettype none

module can_acceptance_filter_table #(
	parameter int FILTER_SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	caft_req_if.sink    cmd,
	caft_rsp_if.source  rsp
);

	caft_pkg::dp_cmd_t dp_cmd;
	caft_pkg::dp_sts_t dp_sts;

	caft_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (cmd.valid),
		.req_ready (cmd.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (dp_sts),
		.cmd       (dp_cmd)
	);

	caft_dp #(
		.FILTER_SLOTS (FILTER_SLOTS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.command          (cmd.command),
		.frame_id         (cmd.frame_id),
		.frame_length     (cmd.frame_length),
		.frame_data       (cmd.frame_data),
		.filter_id        (cmd.filter_id),
		.filter_mask      (cmd.filter_mask),
		.filter_min_level (cmd.filter_min_level),
		.cmd              (dp_cmd),
		.sts              (dp_sts),
		.accepted         (rsp.accepted),
		.status           (rsp.status),
		.matched_index    (rsp.matched_index),
		.filter_total     (rsp.filter_total)
	);

endmodule

`default_nettype wire

[test/can_acceptance_filter_table_tb.sv]
// Self-checking testbench for the CAN acceptance filter table: random and directed requests.
`timescale 1ns / 100ps

module can_acceptance_filter_table_tb;

	localparam int FILTER_SLOTS    = 16;
	localparam int PHASE_COUNT     = 4;
	localparam int ITEMS_PER_PHASE = 385;
	localparam int TAIL_CYCLES     = 40;
	localparam int CYCLE_LIMIT     = 400000;

	typedef struct {
		logic                          command;
		logic [caft_pkg::ID_W-1:0]     frame_id;
		logic [caft_pkg::LEN_W-1:0]    frame_length;
		logic [caft_pkg::DATA_W-1:0]   frame_data;
		logic [caft_pkg::ID_W-1:0]     filter_id;
		logic [caft_pkg::ID_W-1:0]     filter_mask;
		logic [caft_pkg::LVL_W-1:0]    filter_min_level;
	} filter_req_t;

	typedef struct {
		logic                          accepted;
		logic [caft_pkg::ST_W-1:0]     status;
		logic [caft_pkg::MIDX_W-1:0]   matched_index;
		logic [caft_pkg::TOT_W-1:0]    filter_total;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	caft_req_if req_ch ();
	caft_rsp_if rsp_ch ();

	can_acceptance_filter_table #(
		.FILTER_SLOTS(FILTER_SLOTS)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (req_ch),
		.rsp    (rsp_ch)
	);

	// Filter table as the block should hold it
	logic [caft_pkg::ID_W-1:0]  tbl_ids    [FILTER_SLOTS];
	logic [caft_pkg::ID_W-1:0]  tbl_masks  [FILTER_SLOTS];
	logic [caft_pkg::LVL_W-1:0] tbl_levels [FILTER_SLOTS];
	int                         tbl_count = 0;

	// Filters as the stimulus has queued them, used to aim frames at entries
	logic [caft_pkg::ID_W-1:0] plan_ids   [FILTER_SLOTS];
	logic [caft_pkg::ID_W-1:0] plan_masks [FILTER_SLOTS];
	int                        plan_count = 0;

	filter_req_t pending_reqs [$];
	verdict_t    expected_verdicts [$];
	filter_req_t in_flight;
	logic        next_valid;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int error_count    = 0;
	int cycle_count    = 0;

	// Work out the response to one request and update the table
	function automatic verdict_t judge_request(filter_req_t r);
		verdict_t    v;
		int          n;
		logic [63:0] byte_sum;
		logic [63:0] lhs;
		logic [63:0] rhs;
		logic        found;
		v.accepted      = 1'b0;
		v.status        = caft_pkg::ST_NOMATCH;
		v.matched_index = '0;
		found           = 1'b0;
		if (r.command == caft_pkg::CMD_ADD) begin
			if (tbl_count >= FILTER_SLOTS) begin
				v.status = caft_pkg::ST_FULL;
			end else begin
				tbl_ids[tbl_count]    = r.filter_id;
				tbl_masks[tbl_count]  = r.filter_mask;
				tbl_levels[tbl_count] = r.filter_min_level;
				tbl_count++;
				v.accepted = 1'b1;
				v.status   = caft_pkg::ST_ADDED;
			end
		end else if (tbl_count == 0) begin
			v.accepted = 1'b1;
			v.status   = caft_pkg::ST_EMPTY;
		end else begin
			// Saturate the length and sum the bytes it covers
			n        = (r.frame_length > 4'd8) ? 8 : int'(r.frame_length);
			byte_sum = '0;
			for (int i = 0; i < n; i++)
				byte_sum += 64'(r.frame_data[8*i +: 8]);
			// First filter that matches under its mask and passes its level decides
			for (int k = 0; k < tbl_count; k++) begin
				lhs = 64'd5000 * byte_sum;
				rhs = 64'(tbl_levels[k]) * 64'd255 * 64'(n);
				if (!found && ((r.frame_id & tbl_masks[k]) == (tbl_ids[k] & tbl_masks[k]))
				    && lhs >= rhs) begin
					found           = 1'b1;
					v.matched_index = k[caft_pkg::MIDX_W-1:0];
					if (r.frame_id[caft_pkg::ERR_BIT]) begin
						v.status = caft_pkg::ST_ERROR;
					end else begin
						v.accepted = 1'b1;
						v.status   = caft_pkg::ST_MATCH;
					end
				end
			end
		end
		v.filter_total = tbl_count[caft_pkg::TOT_W-1:0];
		return v;
	endfunction

	// Request with every field random; callers overwrite what matters
	function automatic filter_req_t noise_req();
		filter_req_t r;
		r.command          = ($urandom_range(0, 1) == 0) ? caft_pkg::CMD_CHECK
		                                                 : caft_pkg::CMD_ADD;
		r.frame_id         = $urandom;
		r.frame_length     = caft_pkg::LEN_W'($urandom_range(0, 15));
		r.frame_data       = {$urandom, $urandom};
		r.filter_id        = $urandom;
		r.filter_mask      = $urandom;
		r.filter_min_level = caft_pkg::LVL_W'($urandom_range(0, 8191));
		return r;
	endfunction

	task automatic queue_add(logic [caft_pkg::ID_W-1:0] id, logic [caft_pkg::ID_W-1:0] mask,
	                         logic [caft_pkg::LVL_W-1:0] level);
		filter_req_t r;
		r                  = noise_req();
		r.command          = caft_pkg::CMD_ADD;
		r.filter_id        = id;
		r.filter_mask      = mask;
		r.filter_min_level = level;
		if (plan_count < FILTER_SLOTS) begin
			plan_ids[plan_count]   = id;
			plan_masks[plan_count] = mask;
			plan_count++;
		end
		pending_reqs.push_back(r);
	endtask

	task automatic queue_check(logic [caft_pkg::ID_W-1:0] id, logic [caft_pkg::LEN_W-1:0] len,
	                           logic [caft_pkg::DATA_W-1:0] data);
		filter_req_t r;
		r              = noise_req();
		r.command      = caft_pkg::CMD_CHECK;
		r.frame_id     = id;
		r.frame_length = len;
		r.frame_data   = data;
		pending_reqs.push_back(r);
	endtask

	// Mostly checks aimed at a queued filter; adds keep filling the table
	task automatic queue_random_req();
		logic [caft_pkg::ID_W-1:0]   id;
		logic [caft_pkg::ID_W-1:0]   mask;
		logic [caft_pkg::LEN_W-1:0]  len;
		logic [caft_pkg::DATA_W-1:0] data;
		logic [caft_pkg::LVL_W-1:0]  level;
		int                          k;
		if ($urandom_range(0, 99) < 12) begin
			case ($urandom_range(0, 5))
				0: mask = 32'h0000_07FF;
				1: mask = 32'h1FFF_FFFF;
				2: mask = 32'hFFFF_FFFF;
				3: mask = 32'h0000_0000;
				default: mask = $urandom;
			endcase
			if (mask == '0)
				level = caft_pkg::LVL_W'($urandom_range(3000, 8191));
			else if ($urandom_range(0, 3) == 0)
				level = caft_pkg::LVL_W'($urandom_range(0, 8191));
			else
				level = caft_pkg::LVL_W'($urandom_range(0, 5000));
			queue_add($urandom, mask, level);
		end else begin
			len = ($urandom_range(0, 4) == 0) ? caft_pkg::LEN_W'($urandom_range(9, 15))
			                                  : caft_pkg::LEN_W'($urandom_range(0, 8));
			case ($urandom_range(0, 3))
				0: data = {$urandom, $urandom};
				1: data = {8{8'($urandom_range(0, 255))}};
				2: data = '0;
				default: data = '1;
			endcase
			id = $urandom;
			if (plan_count > 0 && $urandom_range(0, 9) < 7) begin
				k  = $urandom_range(0, plan_count - 1);
				id = (plan_ids[k] & plan_masks[k]) | ($urandom & ~plan_masks[k]);
				if ($urandom_range(0, 3) == 0)
					id[caft_pkg::ERR_BIT] = 1'($urandom_range(0, 1));
			end
			queue_check(id, len, data);
		end
	endtask

	// Wait until every request is taken and every response has come back
	task automatic wait_drained();
		@(negedge clk);
		while (pending_reqs.size() != 0 || req_ch.valid || expected_verdicts.size() != 0)
			@(negedge clk);
	endtask

	// Clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Request driver: predict on accept, then present the next request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid            <= 1'b0;
			req_ch.command          <= caft_pkg::CMD_CHECK;
			req_ch.frame_id         <= '0;
			req_ch.frame_length     <= '0;
			req_ch.frame_data       <= '0;
			req_ch.filter_id        <= '0;
			req_ch.filter_mask      <= '0;
			req_ch.filter_min_level <= '0;
		end else begin
			next_valid = req_ch.valid && !req_ch.ready;
			if (req_ch.valid && req_ch.ready)
				expected_verdicts.push_back(judge_request(in_flight));
			if (!next_valid && pending_reqs.size() != 0
			    && $urandom_range(0, 99) >= send_idle_pct) begin
				in_flight               = pending_reqs.pop_front();
				next_valid              = 1'b1;
				req_ch.command          <= in_flight.command;
				req_ch.frame_id         <= in_flight.frame_id;
				req_ch.frame_length     <= in_flight.frame_length;
				req_ch.frame_data       <= in_flight.frame_data;
				req_ch.filter_id        <= in_flight.filter_id;
				req_ch.filter_mask      <= in_flight.filter_mask;
				req_ch.filter_min_level <= in_flight.filter_min_level;
			end
			req_ch.valid <= next_valid;
		end
	end

	// Response monitor: compare against the oldest expectation, stall at random
	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_verdicts.size() == 0) begin
					$error("response with no request outstanding");
					error_count++;
				end else begin
					want = expected_verdicts.pop_front();
					if (rsp_ch.accepted !== want.accepted) begin
						$error("accepted: expected %0d, got %0d", want.accepted, rsp_ch.accepted);
						error_count++;
					end
					if (rsp_ch.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp_ch.status);
						error_count++;
					end
					if (rsp_ch.matched_index !== want.matched_index) begin
						$error("matched_index: expected %0d, got %0d",
						       want.matched_index, rsp_ch.matched_index);
						error_count++;
					end
					if (rsp_ch.filter_total !== want.filter_total) begin
						$error("filter_total: expected %0d, got %0d",
						       want.filter_total, rsp_ch.filter_total);
						error_count++;
					end
				end
			end
			rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Stimulus: directed requests, then random phases with different idling
	initial begin
		int send_pct [PHASE_COUNT];
		int recv_pct [PHASE_COUNT];
		send_pct = '{0, 77, 0, 32};
		recv_pct = '{0, 0, 77, 32};

		// Drive every input before the first edge
		req_ch.valid            = 1'b0;
		req_ch.command          = caft_pkg::CMD_CHECK;
		req_ch.frame_id         = '0;
		req_ch.frame_length     = '0;
		req_ch.frame_data       = '0;
		req_ch.filter_id        = '0;
		req_ch.filter_mask      = '0;
		req_ch.filter_min_level = '0;
		rsp_ch.ready            = 1'b0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Empty table accepts anything, error bit and long length included
		queue_check(32'hFFFF_FFFF, 4'd15, '1);
		queue_check(32'h0000_0000, 4'd0, '0);
		// Highest threshold only passes a zero-length frame
		queue_add(32'h0000_0123, 32'h0000_07FF, 13'd8191);
		queue_check(32'h0000_0123, 4'd0, '0);
		queue_check(32'h0000_0123, 4'd8, '1);
		queue_check(32'h2000_0123, 4'd0, '1);
		// Full-scale level meets a 5000 mV threshold exactly; error bit reported
		queue_add(32'hFFFF_FFFF, 32'hFFFF_FFFF, 13'd5000);
		queue_check(32'hFFFF_FFFF, 4'd8, '1);
		queue_check(32'hDFFF_FFFF, 4'd8, '1);
		// Saturated length, bytes past the length ignored, level boundary
		queue_add(32'h0000_0000, 32'h1FFF_FFFF, 13'd2500);
		queue_check(32'h2000_0000, 4'd12, {8{8'd128}});
		queue_check(32'h0000_0000, 4'd2, 64'hFFFF_FFFF_FFFF_0000);
		queue_check(32'h0000_0000, 4'd4, 64'hFFFF_FFFF_8080_7F7F);
		queue_check(32'h0000_0000, 4'd4, 64'hFFFF_FFFF_7F7F_7F7F);
		queue_add(32'h0000_ABCD, 32'h0000_FFFF, 13'd0);
		queue_check(32'h1234_ABCD, 4'd9, {$urandom, $urandom});

		for (int p = 0; p < PHASE_COUNT; p++) begin
			send_idle_pct  = send_pct[p];
			recv_stall_pct = recv_pct[p];
			repeat (ITEMS_PER_PHASE) queue_random_req();
			wait_drained();
		end

		// Let any stray response show up
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
